[src/s5st_pkg.sv]
// s5st_pkg: shared types and constants for the s5 sleep-type scanner
// used by every module under src; no dependencies
`timescale 1ns / 1ps

package s5st_pkg;

    localparam int          HEADER_BYTES_DEF = 36;

    localparam logic [31:0] PATTERN_WORD = 32'h5F53355F;   // "_S5_"
    localparam logic [7:0]  PKG_OPCODE   = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX  = 8'h0A;
    localparam logic [31:0] OFFSET_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        PH_SEARCH   = 3'd0,
        PH_PKGOP    = 3'd1,
        PH_LEAD     = 3'd2,
        PH_SKIP     = 3'd3,
        PH_COUNT    = 3'd4,
        PH_ELEM     = 3'd5,
        PH_PREFIXED = 3'd6,
        PH_DONE     = 3'd7
    } s5st_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } s5st_item_t;

    typedef struct packed {
        logic [7:0] sleep_type;
        logic       found;
    } s5st_result_t;

endpackage

[src/s5st_in_reg.sv]
// s5st_in_reg: input register stage holding one table byte
// depends on s5st_pkg
`timescale 1ns / 1ps

module s5st_in_reg
    import s5st_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,     // last_byte
    input  logic       advance,
    output logic       item_valid,
    output s5st_item_t item
);

    logic       valid_reg, valid_next;
    s5st_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

[src/s5st_parser.sv]
// s5st_parser: per-byte table parser, pattern search and package decode
// depends on s5st_pkg
`timescale 1ns / 1ps

module s5st_parser
    import s5st_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  s5st_item_t   item,
    input  logic         out_free,
    output logic         advance,
    output logic         res_valid,
    output s5st_result_t res
);

    localparam logic [31:0] MATCH_MIN = 32'(HEADER_BYTES) + 32'd3;

    s5st_phase_t phase_reg, phase_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] len_reg, len_next;
    logic [23:0] recent_reg, recent_next;
    logic [1:0]  skip_reg, skip_next;
    logic        answered_reg, answered_next;

    logic        consume;
    logic [7:0]  b;
    logic [31:0] len_cur;
    logic [31:0] window;
    logic        active;
    logic        hit;
    logic        val_hit;

    assign advance = out_free;
    assign consume = item_valid && out_free;
    assign b       = item.data_byte;

    // length field sits at offsets 4..7, little-endian
    always_comb begin
        len_cur = len_reg;
        if (off_reg[31:2] == 30'd1) begin
            len_cur = len_reg | (32'(b) << {off_reg[1:0], 3'b000});
        end
    end

    assign window = {recent_reg, b};
    assign active = !answered_reg && (off_reg < len_cur);
    assign hit    = (window == PATTERN_WORD) && (off_reg >= MATCH_MIN) &&
                    (({1'b0, off_reg} + 33'd1) < {1'b0, len_cur});

    // outputs
    always_comb begin
        val_hit = 1'b0;
        if (consume && active) begin
            unique case (phase_reg)
                PH_ELEM:     val_hit = (b != BYTE_PREFIX);
                PH_PREFIXED: val_hit = 1'b1;
                default:     val_hit = 1'b0;
            endcase
        end
        res_valid      = val_hit || (consume && item.last_byte && !answered_reg);
        res.sleep_type = val_hit ? b : 8'd0;
        res.found      = val_hit;
    end

    // next state
    always_comb begin
        phase_next    = phase_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        recent_next   = recent_reg;
        skip_next     = skip_reg;
        answered_next = answered_reg;
        if (consume) begin
            len_next = len_cur;
            if (active) begin
                unique case (phase_reg)
                    PH_SEARCH: begin
                        if (hit) begin
                            recent_next = '0;
                            phase_next  = PH_PKGOP;
                        end else begin
                            recent_next = window[23:0];
                        end
                    end
                    PH_PKGOP: begin
                        if (b == PKG_OPCODE) begin
                            phase_next = PH_LEAD;
                        end else begin
                            recent_next = '0;
                            phase_next  = PH_SEARCH;
                        end
                    end
                    PH_LEAD: begin
                        skip_next  = b[7:6];
                        phase_next = (b[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
                    end
                    PH_SKIP: begin
                        skip_next = skip_reg - 2'd1;
                        if (skip_reg == 2'd1) begin
                            phase_next = PH_COUNT;
                        end
                    end
                    PH_COUNT: phase_next = PH_ELEM;
                    PH_ELEM: begin
                        if (b == BYTE_PREFIX) begin
                            phase_next = PH_PREFIXED;
                        end else begin
                            answered_next = 1'b1;
                            phase_next    = PH_DONE;
                        end
                    end
                    PH_PREFIXED: begin
                        answered_next = 1'b1;
                        phase_next    = PH_DONE;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            if (off_reg != OFFSET_MAX) begin
                off_next = off_reg + 32'd1;
            end
            // final byte starts a fresh table
            if (item.last_byte) begin
                phase_next    = PH_SEARCH;
                off_next      = '0;
                len_next      = '0;
                recent_next   = '0;
                skip_next     = '0;
                answered_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEARCH;
            off_reg      <= '0;
            len_reg      <= '0;
            recent_reg   <= '0;
            skip_reg     <= '0;
            answered_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            off_reg      <= off_next;
            len_reg      <= len_next;
            recent_reg   <= recent_next;
            skip_reg     <= skip_next;
            answered_reg <= answered_next;
        end
    end

endmodule

[src/s5st_out_reg.sv]
// s5st_out_reg: result register feeding the master stream
// depends on s5st_pkg
`timescale 1ns / 1ps

module s5st_out_reg
    import s5st_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         res_valid,
    input  s5st_result_t res,
    output logic         out_free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [7:0] sleep_type
    output logic         m_tuser    // found
);

    logic         valid_reg, valid_next;
    s5st_result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.sleep_type;
    assign m_tuser  = res_reg.found;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

[src/aml_s5_sleep_type_scanner_core.sv]
// aml_s5_sleep_type_scanner_core: top level of the s5 sleep-type scanner
// path: input register, parser, then result register, whose valid drives m_tvalid
// throughput: one byte per cycle while out_free, limited by the one parser update per byte
// at most one result per table, on the value byte or on the final byte
// reset: aresetn synchronous active low, clears both stage valids and all parser state
// depends on s5st_pkg, s5st_in_reg, s5st_parser, s5st_out_reg
`timescale 1ns / 1ps

module aml_s5_sleep_type_scanner_core
    import s5st_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF    // earliest offset of the pattern
) (
    input  logic       aclk,
    input  logic       aresetn,
    // byte stream in
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] data_byte
    input  logic       s_tlast,      // last_byte, final byte of the table
    // result stream out
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] sleep_type
    output logic       m_tuser       // found
);

    // registered byte between input stage and parser
    logic         item_valid;
    s5st_item_t   item;
    // parser may consume when the result register has room this cycle
    logic         advance;
    logic         out_free;
    // parser result toward the output register
    logic         res_valid;
    s5st_result_t res;

    // input stage: takes a new transaction when empty or whenever the held byte moves on
    s5st_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // parser: length capture, pattern window, package decode, default on final byte
    s5st_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register: holds one transaction while the sink stalls
    s5st_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[test/aml_s5_sleep_type_scanner_core_tb.sv]
// aml_s5_sleep_type_scanner_core_tb: self-checking bench for the s5 sleep-type scanner
// streams short acpi-like tables, predicts each sleep-type result and checks it in order
// depends on s5st_pkg and aml_s5_sleep_type_scanner_core
`timescale 1ns / 1ps

module aml_s5_sleep_type_scanner_core_tb;
    import s5st_pkg::*;

    localparam int HDR        = HEADER_BYTES_DEF;
    localparam int MIN_TABLES = 30;        // results are one per table, so keep going
    localparam int MIN_BYTES  = 1700;
    localparam int LIMIT      = 400000;    // cycles, far above the slowest passing run

    // tracks the scanner state per byte and holds the sleep-type results still owed
    class s5_value_tracker;
        s5st_result_t   pending_types[$];
        int             errors;
        logic [31:0]    next_off;
        logic [31:0]    tbl_len;
        logic [23:0]    history;
        s5st_phase_t    phase;
        logic [1:0]     skips_left;
        logic           answered;

        function new();
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            next_off   = '0;
            tbl_len    = '0;
            history    = '0;
            phase      = PH_SEARCH;
            skips_left = '0;
            answered   = 1'b0;
        endfunction

        function void give_value(logic [7:0] v);
            pending_types.push_back('{sleep_type: v, found: 1'b1});
            answered = 1'b1;
            phase    = PH_DONE;
        endfunction

        // one accepted byte transaction
        function void note_byte(logic [7:0] b, logic lst);
            logic [31:0] pos;
            logic [31:0] win;
            pos = next_off;
            if (pos >= 4 && pos <= 7)
                tbl_len = tbl_len | (32'(b) << (8 * (pos - 4)));
            if (!answered && pos < tbl_len) begin
                case (phase)
                    PH_SEARCH: begin
                        win = {history, b};
                        if (win == PATTERN_WORD && pos >= HDR + 3 &&
                            {32'd0, pos} + 64'd1 < {32'd0, tbl_len}) begin
                            history = '0;
                            phase   = PH_PKGOP;
                        end else begin
                            history = win[23:0];
                        end
                    end
                    PH_PKGOP: begin
                        if (b == PKG_OPCODE) begin
                            phase = PH_LEAD;
                        end else begin
                            history = '0;
                            phase   = PH_SEARCH;
                        end
                    end
                    PH_LEAD: begin
                        skips_left = b[7:6];
                        phase = (b[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
                    end
                    PH_SKIP: begin
                        skips_left = skips_left - 2'd1;
                        if (skips_left == 2'd0)
                            phase = PH_COUNT;
                    end
                    PH_COUNT:    phase = PH_ELEM;
                    PH_ELEM: begin
                        if (b == BYTE_PREFIX)
                            phase = PH_PREFIXED;
                        else
                            give_value(b);
                    end
                    PH_PREFIXED: give_value(b);
                    default: ;
                endcase
            end
            if (next_off != OFFSET_MAX)
                next_off = next_off + 32'd1;
            if (lst) begin
                if (!answered)
                    pending_types.push_back('{sleep_type: 8'h00, found: 1'b0});
                clear_table();
            end
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        // one accepted result transaction
        task check_result(logic [7:0] sleep_type, logic found);
            s5st_result_t want;
            if (pending_types.size() == 0) begin
                report($sformatf("result %02h/%0b with nothing outstanding", sleep_type, found));
                return;
            end
            want = pending_types.pop_front();
            if (sleep_type !== want.sleep_type)
                report($sformatf("sleep_type %02h, wanted %02h", sleep_type, want.sleep_type));
            if (found !== want.found)
                report($sformatf("found %0b, wanted %0b", found, want.found));
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] data_byte
    logic       s_tlast;     // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [7:0] sleep_type
    logic       m_tuser;     // found

    s5_value_tracker tracker;
    logic [7:0]      tbl_q[$];      // bytes of the table being built
    int              src_idle_pct;
    int              snk_idle_pct;
    int              bytes_sent;
    int              cycles;

    aml_s5_sleep_type_scanner_core #(
        .HEADER_BYTES (HDR)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: sample at the rising edge, change tready at the falling edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser);
            @(negedge aclk);
            m_tready = ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // one byte transaction, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] d, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = lst;
        do @(posedge aclk); while (!s_tready);
        tracker.note_byte(d, lst);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_tbl();
        for (int i = 0; i < tbl_q.size(); i++)
            send_byte(tbl_q[i], i == tbl_q.size() - 1);
    endtask

    task automatic push_rand(input int n);
        for (int i = 0; i < n; i++)
            tbl_q.push_back(8'($urandom));
    endtask

    task automatic push_pattern();
        tbl_q.push_back(PATTERN_WORD[31:24]);
        tbl_q.push_back(PATTERN_WORD[23:16]);
        tbl_q.push_back(PATTERN_WORD[15:8]);
        tbl_q.push_back(PATTERN_WORD[7:0]);
    endtask

    // "_S5_", opcode, lead byte with its extra length bytes, count, optional prefix, first element
    task automatic push_package();
        logic [1:0] k;
        logic [7:0] v;
        k = 2'($urandom);
        v = 8'($urandom);
        push_pattern();
        tbl_q.push_back(PKG_OPCODE);
        tbl_q.push_back({k, 6'($urandom)});
        push_rand(k);
        push_rand(1);
        if ($urandom_range(0, 1))
            tbl_q.push_back(BYTE_PREFIX);
        tbl_q.push_back(v);
    endtask

    task automatic build_table();
        int          mode;
        int          n;
        int          start;
        int unsigned len;
        logic [7:0]  bad;
        tbl_q.delete();
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            // noise: random bytes, sometimes a plausible length
            n = $urandom_range(1, 70);
            push_rand(n);
            if (n >= 8 && $urandom_range(0, 1)) begin
                len = $urandom_range(0, n + 4);
                for (int i = 0; i < 4; i++)
                    tbl_q[4 + i] = 8'(len >> (8 * i));
            end
            return;
        end
        push_rand(HDR);
        if (mode == 5) begin
            // pattern inside the header must never match
            start = $urandom_range(8, HDR - 4);
            tbl_q[start]     = PATTERN_WORD[31:24];
            tbl_q[start + 1] = PATTERN_WORD[23:16];
            tbl_q[start + 2] = PATTERN_WORD[15:8];
            tbl_q[start + 3] = PATTERN_WORD[7:0];
        end
        push_rand($urandom_range(0, 6));
        if (mode == 7) begin
            // missing opcode; an underscore there must not start a new match
            push_pattern();
            if ($urandom_range(0, 2) == 0) begin
                tbl_q.push_back(PATTERN_WORD[31:24]);
                tbl_q.push_back(PATTERN_WORD[23:16]);
                tbl_q.push_back(PATTERN_WORD[15:8]);
                tbl_q.push_back(PATTERN_WORD[7:0]);
                tbl_q.push_back(PKG_OPCODE);
            end else begin
                bad = 8'($urandom);
                if (bad == PKG_OPCODE)
                    bad = bad ^ 8'h01;
                tbl_q.push_back(bad);
            end
            push_rand($urandom_range(0, 3));
        end
        push_package();
        // trailing bytes after the value, or none so the value is the final byte
        if ($urandom_range(0, 1))
            push_rand($urandom_range(1, 8));
        len = tbl_q.size();
        if (mode == 8)
            len = $urandom_range(HDR + 1, tbl_q.size());   // package cut off by length
        else if (mode == 4)
            len = len + $urandom_range(1, 300);             // stream ends before length
        else
            push_rand($urandom_range(0, 3));                // ignored bytes past length
        for (int i = 0; i < 4; i++)
            tbl_q[4 + i] = 8'(len >> (8 * i));
    endtask

    initial begin
        int n_tables;
        tracker      = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cycles       = 0;
        bytes_sent   = 0;
        src_idle_pct = 12;
        snk_idle_pct = 72;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // short streams: single byte, partial length, length cut by the final byte, zero length
        tbl_q = '{8'hFF};
        send_tbl();
        tbl_q = '{8'h00, 8'hFF, 8'h00};
        send_tbl();
        tbl_q = '{8'h5F, 8'h53, 8'h35, 8'h5F, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_tbl();
        tbl_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_tbl();

        // random tables in three idling phases
        n_tables = 0;
        while (n_tables < MIN_TABLES || bytes_sent < MIN_BYTES) begin
            if (n_tables < MIN_TABLES / 3) begin
                src_idle_pct = 12;
                snk_idle_pct = 72;
            end else if (n_tables < 2 * MIN_TABLES / 3) begin
                src_idle_pct = 72;
                snk_idle_pct = 12;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            build_table();
            send_tbl();
            n_tables++;
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        // drain, then allow for the input and result registers
        while (tracker.pending_types.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending_types.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
src/s5st_pkg.sv
src/s5st_in_reg.sv
src/s5st_parser.sv
src/s5st_out_reg.sv
src/aml_s5_sleep_type_scanner_core.sv
test/aml_s5_sleep_type_scanner_core_tb.sv
